[rtl/core/bdcc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the button debounce and click classifier.
// No dependencies; every other file of the block imports this package.
package bdcc_pkg;

  localparam int NOW_W      = 48;
  localparam int LOCKOUT_W  = 20;
  localparam int WINDOW_W   = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  // click event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SINGLE = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd2;

  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 20'd30000;
  localparam logic [WINDOW_W-1:0]  WINDOW_RESET  = 24'd400000;

  typedef struct packed {
    logic                 enable;
    logic [LOCKOUT_W-1:0] lockout_us;
    logic [WINDOW_W-1:0]  window_us;
  } cfg_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic       debounced_pressed;
  } res_t;

endpackage

[rtl/core/bdcc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for polls, results and register writes.
// Depends on bdcc_pkg for payload widths.
interface bdcc_in_if import bdcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             pin_level;
  logic [NOW_W-1:0] now_us;
  modport source (output valid, pin_level, now_us, input ready);
  modport sink (input valid, pin_level, now_us, output ready);
endinterface

interface bdcc_out_if import bdcc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       debounced_pressed;
  modport source (output valid, event_res, debounced_pressed, input ready);
  modport sink (input valid, event_res, debounced_pressed, output ready);
endinterface

interface bdcc_cfg_if import bdcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/bdcc_core.sv]
`timescale 1ns / 1ps
// Debounce and click state with its one-pass update for a single poll.
// Depends on bdcc_pkg (cfg_t, res_t, event codes).
module bdcc_core import bdcc_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  cfg_t                 cfg,
  input  logic                 pressed,
  input  logic [TIME_BITS-1:0] now,
  output res_t                 res
);

  logic                 stable_level;
  logic                 pending_click;
  logic [TIME_BITS-1:0] first_press_time;
  logic [TIME_BITS-1:0] last_change_time;

  logic                 stable_level_next;
  logic                 pending_click_next;
  logic [TIME_BITS-1:0] first_press_time_next;
  logic [TIME_BITS-1:0] last_change_time_next;

  logic [TIME_BITS-1:0] since_change;
  logic [TIME_BITS-1:0] since_first;
  logic [TIME_BITS-1:0] lockout_ext;
  logic [TIME_BITS-1:0] window_ext;
  logic                 change_ok;
  logic                 in_window;
  logic [1:0]           event_res;

  // elapsed time wraps modulo 2^TIME_BITS
  assign since_change = now - last_change_time;
  assign since_first  = now - first_press_time;
  assign lockout_ext  = TIME_BITS'(cfg.lockout_us);
  assign window_ext   = TIME_BITS'(cfg.window_us);
  assign change_ok    = (pressed != stable_level) && (since_change >= lockout_ext);
  assign in_window    = since_first <= window_ext;

  always_comb begin
    stable_level_next     = stable_level;
    pending_click_next    = pending_click;
    first_press_time_next = first_press_time;
    last_change_time_next = last_change_time;
    event_res             = EV_NONE;
    if (cfg.enable) begin
      if (change_ok) begin
        last_change_time_next = now;
        stable_level_next     = pressed;
        if (pressed) begin
          if (pending_click && in_window) begin
            pending_click_next = 1'b0;
            event_res          = EV_DOUBLE;
          end else begin
            pending_click_next    = 1'b1;
            first_press_time_next = now;
          end
        end
      end
      // an accepted press restarts the click at zero age, so it cannot expire here
      if (event_res == EV_NONE && pending_click && !in_window
          && !(change_ok && pressed)) begin
        pending_click_next = 1'b0;
        event_res          = EV_SINGLE;
      end
    end
  end

  assign res.event_res         = event_res;
  assign res.debounced_pressed = cfg.enable & stable_level_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level     <= 1'b0;
      pending_click    <= 1'b0;
      first_press_time <= '0;
      last_change_time <= '0;
    end else if (step) begin
      stable_level     <= stable_level_next;
      pending_click    <= pending_click_next;
      first_press_time <= first_press_time_next;
      last_change_time <= last_change_time_next;
    end
  end

  a_disabled_holds: assert property (@(posedge clk) disable iff (rst)
    step && !cfg.enable |=> $stable(stable_level) && $stable(pending_click)
      && $stable(first_press_time) && $stable(last_change_time))
    else $error("state moved on a disabled poll");

  a_click_clears_pending: assert property (@(posedge clk) disable iff (rst)
    step && (res.event_res == EV_SINGLE || res.event_res == EV_DOUBLE)
      |=> !pending_click)
    else $error("click reported but pending click kept");

  a_change_stamps_time: assert property (@(posedge clk) disable iff (rst)
    step && cfg.enable && change_ok |=> last_change_time == $past(now)
      && stable_level == $past(pressed))
    else $error("accepted change not recorded");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    res.event_res != 2'd3)
    else $error("undefined event code");

endmodule

[rtl/core/button_debounce_click_classifier.sv]
`timescale 1ns / 1ps
// Top level: poll input register, click classifier core, result register
// and configuration registers. Depends on bdcc_pkg, bdcc_if and bdcc_core.
//
//  channel  | dir | payload                          | transfer when
//  poll     | in  | pin_level, now_us                | poll.valid & poll.ready
//  result   | out | event_res, debounced_pressed     | result.valid & result.ready
//  cfg      | in  | index, data                      | cfg.valid & cfg.ready
//
// One poll per cycle unless the result stalls; each poll passes from its transfer
// through the input register, then the classifier update into the result register.
// The state update for a poll happens as it leaves the input register, so the
// next poll sees it in the following cycle.
// Reset (rst, synchronous) clears state and loads the register defaults.
// A stalled result holds both stages; poll.ready drops only when both are full.
module button_debounce_click_classifier import bdcc_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input logic  clk,
  input logic  rst,
  bdcc_in_if.sink   poll,
  bdcc_out_if.source result,
  bdcc_cfg_if.sink  cfg
);

  cfg_t                 cfg_reg;
  logic                 in_valid;
  logic                 in_pressed;
  logic [TIME_BITS-1:0] in_now;
  logic                 out_valid;
  res_t                 out_res;
  res_t                 core_res;
  logic                 advance;
  logic                 step;

  assign advance    = !out_valid || result.ready;
  assign step       = in_valid && advance;
  assign poll.ready = !in_valid || advance;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.enable     <= 1'b0;
      cfg_reg.lockout_us <= LOCKOUT_RESET;
      cfg_reg.window_us  <= WINDOW_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ENABLE:  cfg_reg.enable     <= cfg.data[0];
        CFG_LOCKOUT: cfg_reg.lockout_us <= cfg.data[LOCKOUT_W-1:0];
        CFG_WINDOW:  cfg_reg.window_us  <= cfg.data[WINDOW_W-1:0];
        default: ;  // no register here: drop the write
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (poll.ready) begin
      in_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      in_pressed <= ~poll.pin_level;
      in_now     <= TIME_BITS'(poll.now_us);
    end
  end

  bdcc_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .cfg     (cfg_reg),
    .pressed (in_pressed),
    .now     (in_now),
    .res     (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= core_res;
    end
  end

  assign result.valid             = out_valid;
  assign result.event_res         = out_res.event_res;
  assign result.debounced_pressed = out_res.debounced_pressed;

endmodule
